### rtl/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, constants and calendar tables for the seconds/date converter.
// ----------------------------------------------------------------------------
package csc_pkg;

   // Register ranks from req capture to the rsp output register
   localparam int CSC_LATENCY = 8;
   // Ranks of the date->seconds path from its final add to the output
   localparam int D2S_DELAY   = CSC_LATENCY - 3;

   localparam logic KIND_D2S = 1'b0;
   localparam logic KIND_S2D = 1'b1;

   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
   localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
   localparam logic [10:0] DAYS_YEAR      = 11'd365;
   localparam logic [11:0] BASE_YEAR      = 12'd2000;

   // Day offsets of the second, third and fourth year of a four-year group
   localparam logic [10:0] YEAR1_START = DAYS_LEAP_YEAR;
   localparam logic [10:0] YEAR2_START = DAYS_LEAP_YEAR + DAYS_YEAR;
   localparam logic [10:0] YEAR3_START = DAYS_LEAP_YEAR + DAYS_YEAR + DAYS_YEAR;

   // Reciprocals for constant division
   // day:  floor(2^35 / 675) on secs >> 7, off by at most one (corrected later)
   // hour: ceil(2^21 / 225) on rem >> 4, exact for rem < 86400
   // quad: ceil(2^27 / 1461), exact for 16-bit day counts
   // min:  ceil(2^14 / 15) on rest >> 2, exact for rest < 3600
   localparam logic [25:0] DAY_RECIP  = 26'd50903316;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [16:0] QUAD_RECIP = 17'd91868;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   typedef struct packed {
      logic        kind;
      logic [31:0] seconds_in;
      logic [11:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [4:0]  hour_in;
      logic [5:0]  minute_in;
      logic [5:0]  second_in;
   } csc_req_type;

   typedef struct packed {
      logic [31:0] seconds_out;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
   } csc_rsp_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } csc_date_type;

   // Days in the months before the given one; months above twelve count the
   // whole year. The leap day counts once February is passed.
   function automatic logic [8:0] cum_days_before(input logic [3:0] month,
                                                  input logic       leap);
      logic [8:0] base;
      case (month) inside
         4'd0, 4'd1: base = 9'd0;
         4'd2:       base = 9'd31;
         4'd3:       base = 9'd59;
         4'd4:       base = 9'd90;
         4'd5:       base = 9'd120;
         4'd6:       base = 9'd151;
         4'd7:       base = 9'd181;
         4'd8:       base = 9'd212;
         4'd9:       base = 9'd243;
         4'd10:      base = 9'd273;
         4'd11:      base = 9'd304;
         4'd12:      base = 9'd334;
         default:    base = 9'd365;
      endcase
      return base + ((leap && (month >= 4'd3)) ? 9'd1 : 9'd0);
   endfunction

endpackage

### rtl/csc_d2s.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_d2s
// Date to seconds datapath: four arithmetic ranks, then a delay line that
// lines the result up with the seconds-to-date path.
// ----------------------------------------------------------------------------
module csc_d2s (
   input  logic                clock,
   input  logic                advance,
   input  csc_pkg::csc_req_type req,
   output logic [31:0]         seconds
);
   import csc_pkg::*;

   logic [11:0] year_dist;
   logic [12:0] dist_rnd;
   logic [20:0] daysa1_in, daysa1_ff;
   logic [8:0]  msum1_in, msum1_ff;
   logic [4:0]  day1_ff, hour1_ff;
   logic [5:0]  minute1_ff, second1_ff;

   logic [31:0] days2_in, days2_ff;
   logic [16:0] tod2_in, tod2_ff;

   logic [48:0] dprod;
   logic [31:0] dsec3_ff;
   logic [16:0] tod3_ff;

   logic [31:0] sec4_in;
   logic [31:0] delay_ff [D2S_DELAY];

   // rank 1: whole years, leap days, month table
   always_comb begin
      year_dist = req.year_in - BASE_YEAR;
      dist_rnd  = 13'(year_dist) + 13'd3;
      daysa1_in = 21'(year_dist) * 21'(DAYS_YEAR) + 21'(dist_rnd >> 2);
      msum1_in  = cum_days_before(req.month_in, year_dist[1:0] == 2'b00);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         daysa1_ff  <= daysa1_in;
         msum1_ff   <= msum1_in;
         day1_ff    <= req.day_in;
         hour1_ff   <= req.hour_in;
         minute1_ff <= req.minute_in;
         second1_ff <= req.second_in;
      end
   end

   // rank 2: day count (wraps on day zero) and time of day
   always_comb begin
      days2_in = 32'(daysa1_ff) + 32'(msum1_ff) + 32'(day1_ff) - 32'd1;
      tod2_in  = 17'(hour1_ff) * 17'(SECS_PER_HOUR) + 17'(minute1_ff) * 17'(SECS_PER_MIN)
               + 17'(second1_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         days2_ff <= days2_in;
         tod2_ff  <= tod2_in;
      end
   end

   // rank 3: days to seconds, mod 2^32
   assign dprod = 49'(days2_ff) * 49'(SECS_PER_DAY);

   always_ff @(posedge clock) begin
      if (advance) begin
         dsec3_ff <= dprod[31:0];
         tod3_ff  <= tod2_ff;
      end
   end

   // rank 4 and delay line
   assign sec4_in = dsec3_ff + 32'(tod3_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         delay_ff[0] <= sec4_in;
         for (int i = 1; i < D2S_DELAY; i++) begin
            delay_ff[i] <= delay_ff[i-1];
         end
      end
   end

   assign seconds = delay_ff[D2S_DELAY-1];

endmodule

### rtl/csc_s2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_s2d
// Seconds to date datapath: eight ranks of reciprocal divides, year split
// and month search.
// ----------------------------------------------------------------------------
module csc_s2d (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [31:0]          seconds_in,
   output csc_pkg::csc_date_type date
);
   import csc_pkg::*;

   // rank 1
   logic [50:0] day_prod;
   logic [31:0] secs1_ff;
   logic [15:0] qe1_ff;
   // rank 2
   logic [32:0] qe_secs;
   logic [17:0] rem2_in, rem2_ff;
   logic [15:0] qe2_ff;
   // rank 3
   logic [15:0] days3_in, days3_ff;
   logic [16:0] rem3_in, rem3_ff;
   // rank 4
   logic [26:0] hprod;
   logic [32:0] qprod;
   logic [4:0]  hour4_ff;
   logic [5:0]  quads4_ff;
   logic [16:0] rem4_ff;
   logic [15:0] days4_ff;
   // rank 5
   logic [16:0] hsecs;
   logic [15:0] qdays;
   logic [11:0] rest5_ff, ybase5_ff;
   logic [10:0] dq5_ff;
   logic [4:0]  hour5_ff;
   // rank 6
   logic [20:0] mprod;
   logic [1:0]  yoff;
   logic [8:0]  yday6_in, yday6_ff;
   logic [11:0] rest6_ff, year6_ff;
   logic [5:0]  minute6_ff;
   logic [4:0]  hour6_ff;
   logic        leap6_ff;
   // rank 7
   logic [11:0] msecs;
   logic [8:0]  jday7_in, jday7_ff;
   logic [3:0]  month7_in, month7_ff;
   logic [5:0]  second7_ff, minute7_ff;
   logic [4:0]  hour7_ff;
   logic [11:0] year7_ff;
   logic        leap7_ff;
   // rank 8
   logic [8:0]   day8_full;
   csc_date_type date_ff;

   // rank 1: day quotient estimate, may be one low
   assign day_prod = 51'(seconds_in[31:7]) * 51'(DAY_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         secs1_ff <= seconds_in;
         qe1_ff   <= day_prod[50:35];
      end
   end

   // rank 2: remainder against the estimate, below two days
   assign qe_secs = 33'(qe1_ff) * 33'(SECS_PER_DAY);
   assign rem2_in = secs1_ff[17:0] - qe_secs[17:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem2_ff <= rem2_in;
         qe2_ff  <= qe1_ff;
      end
   end

   // rank 3: fix up the estimate
   always_comb begin
      if (rem2_ff >= 18'(SECS_PER_DAY)) begin
         days3_in = qe2_ff + 16'd1;
         rem3_in  = 17'(rem2_ff - 18'(SECS_PER_DAY));
      end else begin
         days3_in = qe2_ff;
         rem3_in  = rem2_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         days3_ff <= days3_in;
         rem3_ff  <= rem3_in;
      end
   end

   // rank 4: hour and four-year groups
   assign hprod = 27'(rem3_ff[16:4]) * 27'(HOUR_RECIP);
   assign qprod = 33'(days3_ff) * 33'(QUAD_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         hour4_ff  <= hprod[25:21];
         quads4_ff <= qprod[32:27];
         rem4_ff   <= rem3_ff;
         days4_ff  <= days3_ff;
      end
   end

   // rank 5: remainders after hour and groups
   assign hsecs = 17'(hour4_ff) * 17'(SECS_PER_HOUR);
   assign qdays = 16'(quads4_ff) * 16'(DAYS_PER_QUAD);

   always_ff @(posedge clock) begin
      if (advance) begin
         rest5_ff  <= rem4_ff[11:0] - hsecs[11:0];
         dq5_ff    <= days4_ff[10:0] - qdays[10:0];
         ybase5_ff <= BASE_YEAR + {4'b0000, quads4_ff, 2'b00};
         hour5_ff  <= hour4_ff;
      end
   end

   // rank 6: minute, year within the group
   assign mprod = 21'(rest5_ff[11:2]) * 21'(MIN_RECIP);

   always_comb begin
      if (dq5_ff < YEAR1_START) begin
         yoff     = 2'd0;
         yday6_in = dq5_ff[8:0];
      end else if (dq5_ff < YEAR2_START) begin
         yoff     = 2'd1;
         yday6_in = 9'(dq5_ff - YEAR1_START);
      end else if (dq5_ff < YEAR3_START) begin
         yoff     = 2'd2;
         yday6_in = 9'(dq5_ff - YEAR2_START);
      end else begin
         yoff     = 2'd3;
         yday6_in = 9'(dq5_ff - YEAR3_START);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         minute6_ff <= mprod[19:14];
         rest6_ff   <= rest5_ff;
         hour6_ff   <= hour5_ff;
         year6_ff   <= ybase5_ff + 12'(yoff);
         leap6_ff   <= (yoff == 2'd0);
         yday6_ff   <= yday6_in;
      end
   end

   // rank 7: second, month search over month-end thresholds
   assign msecs    = 12'(minute6_ff) * 12'(SECS_PER_MIN);
   assign jday7_in = yday6_ff + 9'd1;

   always_comb begin
      month7_in = 4'd1;
      for (int m = 1; m < 12; m++) begin
         if (jday7_in > cum_days_before(4'(m + 1), leap6_ff)) begin
            month7_in = month7_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         second7_ff <= rest6_ff[5:0] - msecs[5:0];
         minute7_ff <= minute6_ff;
         hour7_ff   <= hour6_ff;
         year7_ff   <= year6_ff;
         leap7_ff   <= leap6_ff;
         month7_ff  <= month7_in;
         jday7_ff   <= jday7_in;
      end
   end

   // rank 8: day of month
   assign day8_full = jday7_ff - cum_days_before(month7_ff, leap7_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         date_ff.year   <= year7_ff;
         date_ff.month  <= month7_ff;
         date_ff.day    <= day8_full[4:0];
         date_ff.hour   <= hour7_ff;
         date_ff.minute <= minute7_ff;
         date_ff.second <= second7_ff;
      end
   end

   assign date = date_ff;

endmodule

### rtl/calendar_seconds_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_seconds_converter_core
// Converts between seconds since 2000-01-01 00:00:00 and calendar date/time.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction carries kind plus both sets of input fields;
//    kind 0 converts the date fields to seconds, kind 1 the seconds to a date.
//    Fields not used by the selected direction are ignored.
//  - rsp channel: one transaction per req transaction, in order. The fields of
//    the unused direction read as zero.
//  - Pipeline: a fully pipelined 8-rank datapath (8 register ranks, the last
//    being the output register).
//  - Throughput: one transaction per cycle while not stalled; the rank count
//    is set by the seconds-to-date path (day, hour, group and minute
//    reciprocal divides, year split, month search, day subtract).
//  - Stall: the whole pipeline holds while rsp_valid is high and rsp_stall is
//    asserted; req_stall follows so nothing is dropped or repeated. Empty
//    ranks do not collapse while held.
//  - Reset: synchronous, clears all valid bits; no transaction is in flight.
// ----------------------------------------------------------------------------
module calendar_seconds_converter_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  csc_pkg::csc_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csc_pkg::csc_rsp_type  rsp_payload
);
   import csc_pkg::*;

   logic                   advance;
   logic [CSC_LATENCY-1:0] valid_ff;
   logic [CSC_LATENCY-1:0] kind_ff;
   logic [31:0]            d2s_seconds;
   csc_date_type           s2d_date;
   logic                   out_is_s2d;

   // Global pipeline enable: move unless the output holds an untaken result
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Valid and direction tags ride alongside the datapath ranks
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[CSC_LATENCY-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= {kind_ff[CSC_LATENCY-2:0], req_payload.kind};
      end
   end

   csc_d2s u_d2s (
      .clock   (clock),
      .advance (advance),
      .req     (req_payload),
      .seconds (d2s_seconds)
   );

   csc_s2d u_s2d (
      .clock      (clock),
      .advance    (advance),
      .seconds_in (req_payload.seconds_in),
      .date       (s2d_date)
   );

   // Both paths end in registers; pick the one the tag asks for
   assign out_is_s2d = (kind_ff[CSC_LATENCY-1] == KIND_S2D);
   assign rsp_valid  = valid_ff[CSC_LATENCY-1];

   always_comb begin
      rsp_payload = '0;
      if (out_is_s2d) begin
         rsp_payload.year_out   = s2d_date.year;
         rsp_payload.month_out  = s2d_date.month;
         rsp_payload.day_out    = s2d_date.day;
         rsp_payload.hour_out   = s2d_date.hour;
         rsp_payload.minute_out = s2d_date.minute;
         rsp_payload.second_out = s2d_date.second;
      end else begin
         rsp_payload.seconds_out = d2s_seconds;
      end
   end

   // A held pipeline keeps every valid bit in place
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(valid_ff))
      else $error("pipeline valid bits moved while held");

   // Backpressure only comes from an occupied output rank
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending rsp transaction");

   // The last inner rank drains into the output register
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[CSC_LATENCY-2]) |=> rsp_valid)
      else $error("transaction lost before the output register");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits survived reset");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for calendar_seconds_converter_core.
// ----------------------------------------------------------------------------
// An initial block queues transactions for both directions. It starts with a
// directed set: epoch start, the edges of the century, leap days, year and
// group boundaries, and date fields outside their calendar ranges. A random
// mix follows. A negedge driver presents them with random gaps, and the
// result side stalls at random. A posedge monitor computes each expected
// result from an independent date/seconds predictor at the request handshake.
// It then compares every result field in arrival order.
// ----------------------------------------------------------------------------
module tb;
   import csc_pkg::*;

   // Month lengths of a plain year, index 0 unused
   localparam logic [31:0] MONTH_LEN [13] =
      '{32'd0, 32'd31, 32'd28, 32'd31, 32'd30, 32'd31, 32'd30,
        32'd31, 32'd31, 32'd30, 32'd31, 32'd30, 32'd31};
   localparam int unsigned RANDOM_ITEMS = 1450;
   // Seconds from the epoch to 2100-01-01, the end of the exact calendar
   localparam logic [31:0] CENTURY_SECS = 32'd3155760000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   csc_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   csc_rsp_type rsp_payload;

   csc_req_type pending_reqs[$];   // stimulus not yet presented
   csc_rsp_type due_results[$];    // predictions awaiting their result

   int unsigned reqs_offered = 0;  // transactions raised on req_valid
   int unsigned reqs_taken = 0;    // transactions accepted by the block
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;

   // Idle-pattern bookkeeping, each owned by one always block
   int unsigned req_gap = 0;
   int unsigned req_burst = 0;
   int unsigned hold_cycles = 0;
   int unsigned run_cycles = 0;

   calendar_seconds_converter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Calendar predictor
   // ---------------------------------------------------------------------

   // Days in a month; February grows in leap years, months past twelve
   // contribute nothing.
   function automatic logic [31:0] month_days(input logic [31:0] m, input logic leap);
      if (m == 32'd2 && leap)
         return 32'd29;
      if (m > 32'd12)
         return 32'd0;
      return MONTH_LEN[m];
   endfunction

   function automatic csc_rsp_type convert_time(input csc_req_type r);
      csc_rsp_type o;
      logic [11:0] span;
      logic [31:0] days, rest, hh, mm, quads, yr, jday, mon;
      logic        leap;
      o = '0;
      if (r.kind == KIND_D2S) begin
         // Year distance wraps at 12 bits; years before 2000 land far ahead
         span = r.year_in - BASE_YEAR;
         leap = (span[1:0] == 2'd0);
         // One leap day for every started four-year group
         days = 32'(span) * DAYS_YEAR + ((32'(span) + 32'd3) >> 2);
         for (mon = 32'd1; mon < 32'(r.month_in) && mon <= 32'd12; mon++)
            days = days + month_days(mon, leap);
         // Day zero or an oversized day is taken as is, wrapping at 32 bits
         days = days + 32'(r.day_in) - 32'd1;
         o.seconds_out = days * SECS_PER_DAY + 32'(r.hour_in) * SECS_PER_HOUR
                         + 32'(r.minute_in) * SECS_PER_MIN + 32'(r.second_in);
      end else begin
         days = r.seconds_in / SECS_PER_DAY;
         rest = r.seconds_in - days * SECS_PER_DAY;
         hh   = rest / SECS_PER_HOUR;
         rest = rest - hh * SECS_PER_HOUR;
         mm   = rest / SECS_PER_MIN;
         rest = rest - mm * SECS_PER_MIN;
         // Whole four-year groups first, then the leading leap year and the
         // plain years after it
         quads = days / DAYS_PER_QUAD;
         yr    = BASE_YEAR + (quads << 2);
         days  = days - quads * DAYS_PER_QUAD;
         if (days >= DAYS_LEAP_YEAR) begin
            yr   = yr + 32'd1;
            days = days - DAYS_LEAP_YEAR;
            while (days >= DAYS_YEAR) begin
               yr   = yr + 32'd1;
               days = days - DAYS_YEAR;
            end
         end
         leap = (yr[1:0] == 2'd0);
         jday = days + 32'd1;
         mon  = 32'd1;
         while (mon < 32'd12 && jday > month_days(mon, leap)) begin
            jday = jday - month_days(mon, leap);
            mon  = mon + 32'd1;
         end
         o.year_out   = yr[11:0];
         o.month_out  = mon[3:0];
         o.day_out    = jday[4:0];
         o.hour_out   = hh[4:0];
         o.minute_out = mm[5:0];
         o.second_out = rest[5:0];
      end
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers; fields of the unused direction carry random junk
   // ---------------------------------------------------------------------

   function automatic csc_req_type date_req(input int unsigned y, input int unsigned mo,
                                            input int unsigned d, input int unsigned h,
                                            input int unsigned mi, input int unsigned s);
      csc_req_type r;
      r.kind       = KIND_D2S;
      r.seconds_in = $urandom;
      r.year_in    = y[11:0];
      r.month_in   = mo[3:0];
      r.day_in     = d[4:0];
      r.hour_in    = h[4:0];
      r.minute_in  = mi[5:0];
      r.second_in  = s[5:0];
      return r;
   endfunction

   function automatic csc_req_type secs_req(input logic [31:0] s);
      csc_req_type r;
      logic [31:0] junk;
      junk         = $urandom;
      r.kind       = KIND_S2D;
      r.seconds_in = s;
      r.year_in    = junk[11:0];
      r.month_in   = junk[15:12];
      r.day_in     = junk[20:16];
      r.hour_in    = junk[25:21];
      r.minute_in  = junk[31:26];
      r.second_in  = 6'($urandom);
      return r;
   endfunction

   // Mostly short gaps, some medium, a few long
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 88)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: changes inputs on the falling edge only. A new
   // transaction is loaded only once the current one has been accepted, so
   // a stalled payload stays put.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (reqs_taken == reqs_offered) begin
         if (req_gap != 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            reqs_offered = reqs_offered + 1;
            // Occasional back-to-back bursts keep the pipeline full
            if (req_burst != 0) begin
               req_burst = req_burst - 1;
               req_gap = 0;
            end else if ($urandom_range(0, 59) == 0) begin
               req_burst = $urandom_range(20, 80);
               req_gap = 0;
            end else begin
               req_gap = idle_length();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result back-pressure: alternating stall and free stretches, with an
   // occasional long free run.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_cycles == 0 && run_cycles == 0) begin
            hold_cycles = idle_length();
            run_cycles = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 100)
                                                      : $urandom_range(1, 6);
         end
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_stall <= 1'b0;
            run_cycles = run_cycles - 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge, before the block's
   // registers update.
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches = mismatches + 1;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      csc_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            due_results.push_back(convert_time(req_payload));
            reqs_taken = reqs_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected result transaction: %h", rsp_payload);
            end else begin
               want = due_results.pop_front();
               check_field("seconds_out", want.seconds_out, rsp_payload.seconds_out);
               check_field("year_out", 32'(want.year_out), 32'(rsp_payload.year_out));
               check_field("month_out", 32'(want.month_out), 32'(rsp_payload.month_out));
               check_field("day_out", 32'(want.day_out), 32'(rsp_payload.day_out));
               check_field("hour_out", 32'(want.hour_out), 32'(rsp_payload.hour_out));
               check_field("minute_out", 32'(want.minute_out),
                           32'(rsp_payload.minute_out));
               check_field("second_out", 32'(want.second_out),
                           32'(rsp_payload.second_out));
            end
            results_seen = results_seen + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------
   initial begin
      csc_req_type r;
      csc_rsp_type cal;
      int unsigned yr, mo, dy;
      logic [31:0] stamp;

      // Directed: date to seconds
      pending_reqs.push_back(date_req(2000, 1, 1, 0, 0, 0));       // epoch
      pending_reqs.push_back(date_req(2099, 12, 31, 23, 59, 59));  // last second
      pending_reqs.push_back(date_req(2000, 2, 29, 12, 34, 56));   // leap day
      pending_reqs.push_back(date_req(2001, 3, 1, 0, 0, 0));       // plain year, past Feb
      pending_reqs.push_back(date_req(2004, 3, 1, 6, 7, 8));       // leap year, past Feb
      pending_reqs.push_back(date_req(1999, 6, 15, 1, 2, 3));      // year before epoch
      pending_reqs.push_back(date_req(0, 0, 0, 0, 0, 0));          // all zero, day zero
      pending_reqs.push_back(date_req(4095, 15, 31, 31, 63, 63));  // all ones
      pending_reqs.push_back(date_req(2050, 13, 10, 5, 5, 5));     // month past twelve
      pending_reqs.push_back(date_req(2010, 1, 0, 0, 0, 0));       // day zero in January
      pending_reqs.push_back(date_req(2023, 2, 31, 24, 60, 61));   // oversized day and time
      pending_reqs.push_back(date_req(2136, 12, 31, 23, 59, 59));  // wraps past 32 bits

      // Directed: seconds to date
      pending_reqs.push_back(secs_req(32'd0));
      pending_reqs.push_back(secs_req(32'hFFFF_FFFF));
      pending_reqs.push_back(secs_req(32'd86399));
      pending_reqs.push_back(secs_req(32'd86400));
      pending_reqs.push_back(secs_req(32'd59 * 32'd86400));        // 2000-02-29
      pending_reqs.push_back(secs_req(32'd60 * 32'd86400));        // 2000-03-01
      pending_reqs.push_back(secs_req(32'd365 * 32'd86400));       // 2000-12-31
      pending_reqs.push_back(secs_req(32'd366 * 32'd86400));       // 2001-01-01
      pending_reqs.push_back(secs_req(32'd731 * 32'd86400 - 32'd1)); // end of 2001
      pending_reqs.push_back(secs_req(32'd1461 * 32'd86400 - 32'd1)); // end of a group
      pending_reqs.push_back(secs_req(32'd1461 * 32'd86400));      // start of next group
      pending_reqs.push_back(secs_req(CENTURY_SECS));              // 2100-01-01
      pending_reqs.push_back(secs_req(32'hAAAA_AAAA));

      // Random part: mostly calendar-valid input with random content
      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            yr = $urandom_range(2000, 2099);
            mo = $urandom_range(1, 12);
            dy = $urandom_range(1, month_days(mo, (yr % 4) == 0));
            r = date_req(yr, mo, dy, $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59));
            // Some transactions get raw, unchecked field values
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1)) r.year_in = 12'($urandom);
               if ($urandom_range(0, 1)) r.month_in = 4'($urandom);
               if ($urandom_range(0, 1)) r.day_in = 5'($urandom);
               if ($urandom_range(0, 1)) r.hour_in = 5'($urandom);
               if ($urandom_range(0, 1)) r.minute_in = 6'($urandom);
               if ($urandom_range(0, 1)) r.second_in = 6'($urandom);
            end
         end else begin
            case ($urandom_range(0, 2))
               0: stamp = $urandom;
               1: stamp = $urandom_range(0, CENTURY_SECS - 1);
               default: begin
                  // Month start or month end, optionally one second earlier
                  yr = $urandom_range(2000, 2136);
                  mo = $urandom_range(1, 12);
                  dy = $urandom_range(0, 1) ? 1 : month_days(mo, (yr % 4) == 0);
                  cal = convert_time(date_req(yr, mo, dy, 0, 0, 0));
                  stamp = cal.seconds_out;
                  if ($urandom_range(0, 1))
                     stamp = stamp - 32'd1;
               end
            endcase
            r = secs_req(stamp);
         end
         pending_reqs.push_back(r);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || reqs_taken != reqs_offered)
         @(posedge clock);
      while (due_results.size() != 0)
         @(posedge clock);
      // Let any stray result surface
      repeat (4 * CSC_LATENCY) @(posedge clock);

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #4ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
